// File: hw/rtl/svb_pkg.sv
// Shared types and constants for the stereo bargraph level meter.
package svb_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CHAN_W     = 4;
    localparam int COUNT_W    = 13;
    localparam int BRIGHT_W   = 12;
    localparam int DECAY_W    = 13;
    localparam int DUTY_W     = 12;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 12'd2048;
    localparam logic [DUTY_W-1:0]   DUTY_FULL  = 12'd4095;
    localparam logic [COUNT_W-1:0]  FULL_FLAG  = 13'h1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADC_CENTER  = 3'd0,
        REG_FULL_SCALE  = 3'd1,
        REG_PEAK_DECAY  = 3'd2,
        REG_BRIGHTNESS  = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] center;
        logic [SAMPLE_W-1:0] full_scale_amplitude;
        logic [DECAY_W-1:0]  decay_step;
    } front_cfg_t;

endpackage

// File: hw/rtl/svb_front.sv
// Front end: accepts a sample pair, divides to levels, updates the peaks.
module svb_front #(
    parameter int LEVEL_FRAC_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  svb_pkg::front_cfg_t           cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [svb_pkg::SAMPLE_W-1:0]  sample_left,
    input  logic [svb_pkg::SAMPLE_W-1:0]  sample_right,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [2*(LEVEL_FRAC_BITS+1)-1:0] push_peaks
);
    import svb_pkg::*;

    localparam int F    = LEVEL_FRAC_BITS;
    localparam int PW   = F + 1;
    localparam int CNTW = $clog2(F);
    localparam int DW   = DECAY_W + ((F > 12) ? F - 12 : 0);
    localparam int SHL  = (F >= 12) ? F - 12 : 0;
    localparam int SHR  = (F < 12) ? 12 - F : 0;
    localparam logic [PW-1:0] ONE = PW'(1) << F;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CNTW-1:0]     cnt_reg;
    logic [SAMPLE_W-1:0] rem_reg  [2];
    logic [F-1:0]        quot_reg [2];
    logic                sat_reg  [2];
    logic                zero_reg [2];
    logic [PW-1:0]       peak_reg [2];

    logic [SAMPLE_W-1:0] sample [2];
    logic [SAMPLE_W-1:0] amp    [2];
    logic [SAMPLE_W:0]   r2     [2];
    logic                ge     [2];
    logic [PW-1:0]       lvl    [2];
    logic [PW-1:0]       peak_new [2];
    logic [DW-1:0]       decay;

    assign sample[0] = sample_left;
    assign sample[1] = sample_right;
    assign s_ready    = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_peaks = {peak_new[1], peak_new[0]};

    always_comb begin
        if (F >= 12) begin
            decay = DW'(cfg.decay_step) << SHL;
        end else begin
            decay = DW'(cfg.decay_step) >> SHR;
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            amp[j] = (sample[j] >= cfg.center) ? sample[j] - cfg.center
                                               : cfg.center - sample[j];
            r2[j]  = {rem_reg[j], 1'b0};
            ge[j]  = (r2[j] >= {1'b0, cfg.full_scale_amplitude});
            if (zero_reg[j]) begin
                lvl[j] = '0;
            end else if (sat_reg[j]) begin
                lvl[j] = ONE;
            end else begin
                lvl[j] = {1'b0, quot_reg[j]};
            end
            if (lvl[j] > peak_reg[j]) begin
                peak_new[j] = lvl[j];
            end else if (DW'(peak_reg[j]) > decay) begin
                peak_new[j] = PW'(DW'(peak_reg[j]) - decay);
            end else begin
                peak_new[j] = '0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CNTW'(F - 1)) state_next = ST_PUSH;
            ST_PUSH: if (push_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            peak_reg[0] <= '0;
            peak_reg[1] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_PUSH && push_ready) begin
                peak_reg[0] <= peak_new[0];
                peak_reg[1] <= peak_new[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            cnt_reg <= '0;
            for (int j = 0; j < 2; j++) begin
                rem_reg[j]  <= amp[j];
                quot_reg[j] <= '0;
                sat_reg[j]  <= (amp[j] >= cfg.full_scale_amplitude) && (amp[j] != '0);
                zero_reg[j] <= (amp[j] == '0);
            end
        end else if (state_reg == ST_DIV) begin
            cnt_reg <= cnt_reg + CNTW'(1);
            for (int j = 0; j < 2; j++) begin
                rem_reg[j]  <= ge[j] ? SAMPLE_W'(r2[j] - {1'b0, cfg.full_scale_amplitude})
                                     : r2[j][SAMPLE_W-1:0];
                quot_reg[j] <= {quot_reg[j][F-2:0], ge[j]};
            end
        end
    end

endmodule

// File: hw/rtl/svb_queue.sv
// Small FIFO carrying peak pairs from the front end to the segment writer.
module svb_queue #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/svb_back.sv
// Back end: walks the segments of one peak pair and issues the PWM writes.
module svb_back #(
    parameter int SEGMENTS        = 8,
    parameter int LEVEL_FRAC_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [svb_pkg::BRIGHT_W-1:0]   brightness,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  logic [2*(LEVEL_FRAC_BITS+1)-1:0] pop_peaks,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [svb_pkg::CHAN_W-1:0]     m_led_channel,
    output logic [svb_pkg::COUNT_W-1:0]    m_on_count,
    output logic [svb_pkg::COUNT_W-1:0]    m_off_count,
    output logic                           m_last_write
);
    import svb_pkg::*;

    localparam int F   = LEVEL_FRAC_BITS;
    localparam int PW  = F + 1;
    localparam int KW  = $clog2(2 * SEGMENTS);
    localparam int IW  = KW - 1;
    localparam int SW  = PW + $clog2(SEGMENTS);
    localparam int CHW = (KW > CHAN_W) ? KW : CHAN_W;
    localparam int MW  = F + BRIGHT_W;

    logic            active_reg;
    logic [KW-1:0]   k_reg;
    logic [PW-1:0]   pl_reg, pr_reg;
    logic            m_valid_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [COUNT_W-1:0] on_reg, off_reg;
    logic            last_reg;

    logic            adv, last_k, load;
    logic [IW-1:0]   seg;
    logic [PW-1:0]   peak;
    logic [SW-1:0]   s, lo, hi, diff;
    logic [BRIGHT_W-1:0] bright;
    logic [MW-1:0]   prod;
    logic [DUTY_W-1:0] duty;
    logic [CHW-1:0]  chan;
    logic [COUNT_W-1:0] on_next, off_next;

    assign adv       = active_reg && (!m_valid_reg || m_ready);
    assign last_k    = (k_reg == KW'(2 * SEGMENTS - 1));
    assign pop_ready = !active_reg || (adv && last_k);
    assign load      = pop_valid && pop_ready;

    assign m_valid       = m_valid_reg;
    assign m_led_channel = chan_reg;
    assign m_on_count    = on_reg;
    assign m_off_count   = off_reg;
    assign m_last_write  = last_reg;

    always_comb begin
        seg    = k_reg[KW-1:1];
        peak   = k_reg[0] ? pr_reg : pl_reg;
        bright = (brightness > BRIGHT_MAX) ? BRIGHT_MAX : brightness;
        s      = SW'(peak) * SW'(SEGMENTS);
        lo     = SW'(seg) << F;
        hi     = (SW'(seg) + SW'(1)) << F;
        diff   = s - lo;
        prod   = MW'(diff[F-1:0]) * MW'(bright);
        if (s >= hi) begin
            duty = DUTY_W'(bright);
        end else if (s > lo) begin
            duty = prod[MW-1:F];
        end else begin
            duty = '0;
        end
        if (duty >= DUTY_FULL) begin
            on_next  = FULL_FLAG;
            off_next = '0;
        end else if (duty == '0) begin
            on_next  = '0;
            off_next = FULL_FLAG;
        end else begin
            on_next  = '0;
            off_next = COUNT_W'(duty);
        end
        chan = (k_reg[0] ? CHW'(2 * SEGMENTS - 1) : CHW'(SEGMENTS - 1)) - CHW'(seg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            if (load) begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end else if (adv) begin
                if (last_k) begin
                    active_reg <= 1'b0;
                end
                k_reg <= k_reg + KW'(1);
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pl_reg <= pop_peaks[PW-1:0];
            pr_reg <= pop_peaks[2*PW-1:PW];
        end
        if (adv) begin
            chan_reg <= chan[CHAN_W-1:0];
            on_reg   <= on_next;
            off_reg  <= off_next;
            last_reg <= last_k;
        end
    end

endmodule

// File: hw/rtl/stereo_vu_bargraph_pwm_unit.sv
// Top level of the stereo bargraph level meter with peak hold and PWM writes.
//
//  channel  direction  handshake               payload
//  s_       in         s_valid / s_ready       s_sample_left, s_sample_right
//  m_       out        m_valid / m_ready       m_led_channel, m_on_count,
//                                              m_off_count, m_last_write
//  cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each pair yields 2*SEGMENTS writes, one per cycle from the segment writer unless m_ready stalls it.
// The front end's bit-serial divider runs ahead into a two-entry queue, so it
// can start on the next pair while the segment writer still works on the last.
// Reset clears peaks, queue and output valid; registers take their defaults.
// Output stalls back up into the queue and then hold s_ready low.
module stereo_vu_bargraph_pwm_unit #(
    parameter int SEGMENTS        = 8,
    parameter int LEVEL_FRAC_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [svb_pkg::SAMPLE_W-1:0]    s_sample_left,
    input  logic [svb_pkg::SAMPLE_W-1:0]    s_sample_right,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [svb_pkg::CHAN_W-1:0]      m_led_channel,
    output logic [svb_pkg::COUNT_W-1:0]     m_on_count,
    output logic [svb_pkg::COUNT_W-1:0]     m_off_count,
    output logic                            m_last_write,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [svb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import svb_pkg::*;

    localparam int PW = LEVEL_FRAC_BITS + 1;

    logic [SAMPLE_W-1:0] center_reg, fsa_reg;
    logic [DECAY_W-1:0]  decay_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    front_cfg_t          fcfg;

    logic            push_valid, push_ready;
    logic [2*PW-1:0] push_peaks;
    logic            pop_valid, pop_ready;
    logic [2*PW-1:0] pop_peaks;

    assign cfg_ready = 1'b1;
    assign fcfg.center               = center_reg;
    assign fcfg.full_scale_amplitude = fsa_reg;
    assign fcfg.decay_step           = decay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= 12'd2048;
            fsa_reg    <= 12'd2048;
            decay_reg  <= 13'd205;
            bright_reg <= 12'd64;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                REG_ADC_CENTER: center_reg <= cfg_data[SAMPLE_W-1:0];
                REG_FULL_SCALE: fsa_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_PEAK_DECAY: decay_reg  <= cfg_data;
                REG_BRIGHTNESS: bright_reg <= cfg_data[BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    svb_front #(
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (fcfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .sample_left (s_sample_left),
        .sample_right(s_sample_right),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_peaks  (push_peaks)
    );

    svb_queue #(
        .WIDTH(2 * PW),
        .DEPTH(2)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data (push_peaks),
        .rd_valid(pop_valid),
        .rd_ready(pop_ready),
        .rd_data (pop_peaks)
    );

    svb_back #(
        .SEGMENTS       (SEGMENTS),
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .brightness   (bright_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_peaks    (pop_peaks),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_led_channel(m_led_channel),
        .m_on_count   (m_on_count),
        .m_off_count  (m_off_count),
        .m_last_write (m_last_write)
    );

endmodule
